/* src/first_fit_block_allocator_unit_defines.svh */
// Assertion macros used by the allocator datapath.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FFBA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define FFBA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ffba_pkg.sv */
// Types and constants shared by the first-fit allocator modules.
`timescale 1ns / 1ps

package ffba_pkg;

  // Field widths of the request and result transfers.
  localparam int REQ_W  = 15;
  localparam int ADDR_W = 14;
  localparam int USE_W  = 15;
  localparam int CNT_W  = 32;
  localparam int PCT_W  = 7;
  localparam int QUO_W  = 7;

  // Sizes are rounded up to a multiple of four bytes.
  localparam int ROUND_MASK = 3;
  // Full scale of the fragmentation figure.
  localparam int PCT_FULL   = 100;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CHECK = 2'd2,
    OP_STATS = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_NOMEM   = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_DOUBLE  = 3'd4
  } status_e;

  // What the table walker does with each entry it reads.
  typedef enum logic [2:0] {
    MD_FIT   = 3'd0,
    MD_FIND  = 3'd1,
    MD_FRAG  = 3'd2,
    MD_MERGE = 3'd3,
    MD_SHIFT = 3'd4
  } mode_e;

  typedef struct packed {
    op_e                operation;
    logic [REQ_W-1:0]   request_size;
    logic [ADDR_W-1:0]  address;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [ADDR_W-1:0]  granted_address;
    logic               address_valid;
    logic [USE_W-1:0]   used_bytes;
    logic [USE_W-1:0]   used_bytes_max;
    logic [CNT_W-1:0]   allocation_count;
    logic [CNT_W-1:0]   free_count;
    logic [PCT_W-1:0]   fragmentation_percent;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    take;
    logic    init_wr;
    logic    start;
    logic    down;
    mode_e   mode;
    logic    run;
    logic    mend;
    logic    split_wr;
    logic    grant_wr;
    logic    free_wr;
    logic    set_status;
    status_e status;
    logic    set_valid;
    logic    mul;
    logic    div_step;
    logic    load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_e  op;
    logic size_zero;
    logic hit;
    logic hit_use;
    logic split_ok;
    logic done;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

/* src/first_fit_block_allocator_unit.sv */
// Top level of the first-fit block allocator: controller plus datapath.
`timescale 1ns / 1ps

// First-fit heap allocator over an address-ordered block table.
// Input channel: in_valid_i / in_stall_o carry one request transfer
// (allocate, free, address check or statistics read) in in_req_i.
// Output channel: out_valid_o / out_stall_i carry one result transfer per
// request in out_rsp_o; all statistics reflect the state after the request.
// One request is worked at a time. Each request walks the block table one
// entry per cycle through the single read port of the table memory, then a
// setup state and a seven-step divider form the fragmentation figure.
// The result is valid in the cycle after it is loaded into the output
// register, and the block then returns to idle, ready for the next request.
// After reset the block writes the initial free block and then accepts
// requests. A finished result waits in the output register; the next
// request is accepted meanwhile, and the block holds its last state until
// the receiver takes the pending result.
module first_fit_block_allocator_unit #(
  parameter int HEAP_BYTES   = 16384,
  parameter int HEADER_BYTES = 32,
  parameter int MAX_BLOCKS   = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ffba_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ffba_pkg::rsp_t out_rsp_o
);
  import ffba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencing of table walks.
  ffba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Table, counters and result register.
  ffba_dp #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_BLOCKS   (MAX_BLOCKS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

/* src/ffba_div.sv */
// Restoring divider that produces the fragmentation quotient one bit per cycle while step_i is high.
`timescale 1ns / 1ps

module ffba_div #(
  parameter int NUM_W = 21
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     step_i,
  input  logic [NUM_W-1:0]         num_i,
  input  logic [NUM_W-1:0]         den_i,
  output logic [ffba_pkg::QUO_W-1:0] quo_o,
  output logic                     last_o
);
  import ffba_pkg::*;

  localparam int SW = $clog2(QUO_W);

  logic [NUM_W-1:0] rem_q, den_q;
  logic [QUO_W-1:0] quo_q;
  logic [SW-1:0]    cnt_q;
  logic             ge;

  assign ge = (rem_q >= den_q);

  // Step counter is control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= '0;
    end else if (step_i) begin
      cnt_q <= cnt_q + SW'(1);
    end
  end

  // One quotient bit per step, divisor pre-shifted left by QUO_W - 1 bits.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (step_i) begin
      if (ge) begin
        rem_q <= rem_q - den_q;
      end
      quo_q <= {quo_q[QUO_W-2:0], ge};
      den_q <= den_q >> 1;
    end
  end

  assign quo_o  = quo_q;
  assign last_o = (cnt_q == SW'(QUO_W - 1));

endmodule

/* src/ffba_dp.sv */
// Datapath of the allocator: block table memory, table walker, counters and result register.
`timescale 1ns / 1ps
`include "first_fit_block_allocator_unit_defines.svh"

module ffba_dp #(
  parameter int HEAP_BYTES   = 16384,
  parameter int HEADER_BYTES = 32,
  parameter int MAX_BLOCKS   = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ffba_pkg::req_t in_req_i,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output ffba_pkg::rsp_t out_rsp_o,
  input  ffba_pkg::cmd_t cmd_i,
  output ffba_pkg::sts_t sts_o
);
  import ffba_pkg::*;

  localparam int OW = $clog2(HEAP_BYTES);
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int TW = $clog2(MAX_BLOCKS + 1);
  localparam int NW = REQ_W + 1;
  localparam int CW = ((OW > NW) ? OW : NW) + 1;
  localparam int DW = OW + PCT_W;

  typedef struct packed {
    logic          used;
    logic [OW-1:0] pay;
    logic [OW-1:0] off;
  } ent_t;

  ent_t blk_mem [MAX_BLOCKS];

  // Request registers.
  op_e               op_q;
  logic [NW-1:0]     need_q;
  logic [ADDR_W-1:0] addr_q;
  logic              size_zero_q;

  // Table walker.
  logic [TW-1:0] total_q, r_q, r_dec, hit_lim;
  logic          rvld_q, down_q, more, issue, eval, hit, fit_m, find_m, split_ok;
  logic [IW-1:0] ridx_q, raddr;
  ent_t          rd_q;

  // Merge, hit and split state.
  logic [IW-1:0] j_q, hit_idx_q;
  ent_t          pend_q, hit_q;
  logic          pend_vld_q, split_q, both_free;

  // Statistics.
  logic [OW-1:0]    usage_q, peak_q, usage_gnt, grant_pay, largest_q, fsum_q;
  logic [CNT_W-1:0] allocs_q, frees_q;
  logic [1:0]       fcnt_q;
  status_e          status_q;
  logic [ADDR_W-1:0] granted_q;
  logic             valid_q;
  logic [QUO_W-1:0] quo;
  logic             div_last;
  logic [PCT_W-1:0] frag;

  // Result register.
  rsp_t out_q;
  logic out_vld_q;

  // Memory write port.
  logic          we;
  logic [IW-1:0] waddr;
  ent_t          wdata;

  logic [NW-1:0] need_d;

  assign need_d = (NW'(in_req_i.request_size) + NW'(ROUND_MASK)) & ~NW'(ROUND_MASK);

  // Walker address: ascending from zero or descending from the table end.
  assign r_dec   = r_q - TW'(1);
  assign hit_lim = TW'(hit_idx_q) + TW'(1);
  assign more    = down_q ? (r_q > hit_lim) : (r_q < total_q);
  assign raddr   = down_q ? r_dec[IW-1:0] : r_q[IW-1:0];
  assign issue   = cmd_i.run && !cmd_i.start && more;
  assign eval    = cmd_i.run && rvld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q    <= '0;
      rvld_q <= 1'b0;
      down_q <= 1'b0;
    end else if (cmd_i.start) begin
      r_q    <= cmd_i.down ? total_q : '0;
      down_q <= cmd_i.down;
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= issue;
      if (issue) begin
        r_q <= down_q ? r_dec : r_q + TW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      ridx_q <= raddr;
    end
  end

  // Entry match tests for the first-fit and address searches.
  assign fit_m    = !rd_q.used && (CW'(rd_q.pay) >= CW'(need_q));
  assign find_m   = (CW'(rd_q.off) + CW'(HEADER_BYTES)) == CW'(addr_q);
  assign split_ok = (CW'(rd_q.pay) > (CW'(need_q) + CW'(HEADER_BYTES))) &&
                    (total_q < TW'(MAX_BLOCKS));

  always_comb begin
    case (cmd_i.mode)
      MD_FIT:  hit = eval && fit_m;
      MD_FIND: hit = eval && find_m;
      default: hit = 1'b0;
    endcase
  end

  assign both_free = !pend_q.used && !rd_q.used;
  assign grant_pay = split_q ? OW'(need_q) : hit_q.pay;
  assign usage_gnt = usage_q + grant_pay;

  // Single write port shared by all table updates.
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (cmd_i.init_wr) begin
      we        = 1'b1;
      wdata.pay = OW'(HEAP_BYTES - HEADER_BYTES);
    end else if (eval && cmd_i.mode == MD_MERGE && pend_vld_q && !both_free) begin
      we    = 1'b1;
      waddr = j_q;
      wdata = pend_q;
    end else if (cmd_i.mend) begin
      we    = 1'b1;
      waddr = j_q;
      wdata = pend_q;
    end else if (eval && cmd_i.mode == MD_SHIFT) begin
      we    = 1'b1;
      waddr = ridx_q + IW'(1);
      wdata = rd_q;
    end else if (cmd_i.split_wr) begin
      we         = 1'b1;
      waddr      = hit_idx_q + IW'(1);
      wdata.used = 1'b0;
      wdata.pay  = OW'(CW'(hit_q.pay) - CW'(need_q) - CW'(HEADER_BYTES));
      wdata.off  = OW'(CW'(hit_q.off) + CW'(HEADER_BYTES) + CW'(need_q));
    end else if (cmd_i.grant_wr) begin
      we         = 1'b1;
      waddr      = hit_idx_q;
      wdata.used = 1'b1;
      wdata.pay  = grant_pay;
      wdata.off  = hit_q.off;
    end else if (cmd_i.free_wr) begin
      we         = 1'b1;
      waddr      = hit_idx_q;
      wdata.used = 1'b0;
      wdata.pay  = hit_q.pay;
      wdata.off  = hit_q.off;
    end
  end

  // Block table memory with registered read.
  always_ff @(posedge clk_i) begin
    if (we) begin
      blk_mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= blk_mem[raddr];
  end

  // Block count and merge compaction control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= TW'(1);
      j_q        <= '0;
      pend_vld_q <= 1'b0;
    end else begin
      if (cmd_i.init_wr) begin
        total_q <= TW'(1);
      end else if (cmd_i.mend) begin
        total_q <= TW'(j_q) + TW'(1);
      end else if (cmd_i.split_wr) begin
        total_q <= total_q + TW'(1);
      end
      if (cmd_i.start) begin
        j_q        <= '0;
        pend_vld_q <= 1'b0;
      end else if (eval && cmd_i.mode == MD_MERGE) begin
        pend_vld_q <= 1'b1;
        if (pend_vld_q && !both_free) begin
          j_q <= j_q + IW'(1);
        end
      end
    end
  end

  // Pending block of the merge pass: free runs fold into their first block.
  always_ff @(posedge clk_i) begin
    if (eval && cmd_i.mode == MD_MERGE) begin
      if (pend_vld_q && both_free) begin
        pend_q.pay <= pend_q.pay + OW'(HEADER_BYTES) + rd_q.pay;
      end else begin
        pend_q <= rd_q;
      end
    end
  end

  // Request capture and hit capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      op_q        <= in_req_i.operation;
      need_q      <= need_d;
      addr_q      <= in_req_i.address;
      size_zero_q <= (in_req_i.request_size == '0);
    end
    if (hit) begin
      hit_q     <= rd_q;
      hit_idx_q <= ridx_q;
      split_q   <= split_ok;
    end
  end

  // Usage, counters and per-request result fields.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      usage_q   <= '0;
      peak_q    <= '0;
      allocs_q  <= '0;
      frees_q   <= '0;
      status_q  <= ST_OK;
      granted_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      if (cmd_i.take) begin
        status_q  <= ST_OK;
        granted_q <= '0;
        valid_q   <= 1'b0;
      end
      if (cmd_i.set_status) begin
        status_q <= cmd_i.status;
      end
      if (cmd_i.set_valid) begin
        valid_q <= 1'b1;
      end
      if (cmd_i.grant_wr) begin
        usage_q   <= usage_gnt;
        allocs_q  <= allocs_q + CNT_W'(1);
        granted_q <= ADDR_W'(CW'(hit_q.off) + CW'(HEADER_BYTES));
        if (usage_gnt > peak_q) begin
          peak_q <= usage_gnt;
        end
      end
      if (cmd_i.free_wr) begin
        usage_q <= usage_q - hit_q.pay;
        frees_q <= frees_q + CNT_W'(1);
      end
    end
  end

  // Free block statistics gathered during the final walk.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      fcnt_q    <= '0;
      largest_q <= '0;
      fsum_q    <= '0;
    end else if (eval && cmd_i.mode == MD_FRAG && !rd_q.used) begin
      if (fcnt_q != 2'd2) begin
        fcnt_q <= fcnt_q + 2'd1;
      end
      if (rd_q.pay > largest_q) begin
        largest_q <= rd_q.pay;
      end
      fsum_q <= fsum_q + rd_q.pay;
    end
  end

  ffba_div #(
    .NUM_W (DW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul),
    .step_i  (cmd_i.div_step),
    .num_i   (DW'(largest_q) * DW'(PCT_FULL)),
    .den_i   (DW'(fsum_q) << (QUO_W - 1)),
    .quo_o   (quo),
    .last_o  (div_last)
  );

  assign frag = ((fsum_q == '0) || (fcnt_q < 2'd2)) ? '0 : (PCT_W'(PCT_FULL) - quo);

  // Result register parts the work from the receiver.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.status                <= status_q;
      out_q.granted_address       <= granted_q;
      out_q.address_valid         <= valid_q;
      out_q.used_bytes            <= USE_W'(usage_q);
      out_q.used_bytes_max        <= USE_W'(peak_q);
      out_q.allocation_count      <= allocs_q;
      out_q.free_count            <= frees_q;
      out_q.fragmentation_percent <= frag;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;

  // Status back to the controller.
  always_comb begin
    sts_o           = '0;
    sts_o.op        = op_q;
    sts_o.size_zero = size_zero_q;
    sts_o.hit       = hit;
    sts_o.hit_use   = rd_q.used;
    sts_o.split_ok  = split_ok;
    sts_o.done      = !rvld_q && !more;
    sts_o.div_last  = div_last;
    sts_o.out_free  = !out_vld_q || !out_stall_i;
  end

  `FFBA_ASSERT_IMP(a_total_range, 1'b1, (total_q != '0) && (total_q <= TW'(MAX_BLOCKS)), "block count out of range")
  `FFBA_ASSERT_IMP(a_peak_cover, 1'b1, peak_q >= usage_q, "peak usage below current usage")
  `FFBA_ASSERT_IMP(a_out_hold, cmd_i.load_out, !out_vld_q || !out_stall_i, "result overwritten while stalled")
  `FFBA_ASSERT_NXT(a_split_grow, cmd_i.split_wr, total_q == $past(total_q) + TW'(1), "split did not add a block")

endmodule

/* src/ffba_ctrl.sv */
// Controller state machine that sequences table walks for each request.
`timescale 1ns / 1ps

module ffba_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ffba_pkg::sts_t sts_i,
  output ffba_pkg::cmd_t cmd_o
);
  import ffba_pkg::*;

  typedef enum logic [14:0] {
    S_INIT  = 15'b000000000000001,
    S_IDLE  = 15'b000000000000010,
    S_DEC   = 15'b000000000000100,
    S_FIT   = 15'b000000000001000,
    S_MERGE = 15'b000000000010000,
    S_MEND  = 15'b000000000100000,
    S_SHIFT = 15'b000000001000000,
    S_SPLIT = 15'b000000010000000,
    S_GRANT = 15'b000000100000000,
    S_FIND  = 15'b000001000000000,
    S_FREE  = 15'b000010000000000,
    S_FRAG  = 15'b000100000000000,
    S_MUL   = 15'b001000000000000,
    S_DIV   = 15'b010000000000000,
    S_DONE  = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;
  logic   retry_q, retry_d;
  cmd_t   cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      retry_q <= 1'b0;
    end else begin
      state_q <= state_d;
      retry_q <= retry_d;
    end
  end

  // Next state and per-cycle datapath commands.
  always_comb begin
    state_d = state_q;
    retry_d = retry_q;
    cmd     = '0;
    unique case (state_q)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        state_d     = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.take = 1'b1;
          state_d  = S_DEC;
        end
      end
      S_DEC: begin
        retry_d   = 1'b0;
        cmd.start = 1'b1;
        unique case (sts_i.op) inside
          OP_ALLOC: begin
            if (sts_i.size_zero) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_ZERO;
              state_d        = S_FRAG;
            end else begin
              state_d = S_FIT;
            end
          end
          OP_FREE, OP_CHECK: state_d = S_FIND;
          default:           state_d = S_FRAG;
        endcase
      end
      S_FIT: begin
        cmd.run  = 1'b1;
        cmd.mode = MD_FIT;
        if (sts_i.hit) begin
          if (sts_i.split_ok) begin
            cmd.start = 1'b1;
            cmd.down  = 1'b1;
            state_d   = S_SHIFT;
          end else begin
            state_d = S_GRANT;
          end
        end else if (sts_i.done) begin
          cmd.start = 1'b1;
          if (!retry_q) begin
            retry_d = 1'b1;
            state_d = S_MERGE;
          end else begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_NOMEM;
            state_d        = S_FRAG;
          end
        end
      end
      S_SHIFT: begin
        cmd.run  = 1'b1;
        cmd.mode = MD_SHIFT;
        if (sts_i.done) begin
          state_d = S_SPLIT;
        end
      end
      S_SPLIT: begin
        cmd.split_wr = 1'b1;
        state_d      = S_GRANT;
      end
      S_GRANT: begin
        cmd.grant_wr = 1'b1;
        cmd.start    = 1'b1;
        state_d      = S_FRAG;
      end
      S_MERGE: begin
        cmd.run  = 1'b1;
        cmd.mode = MD_MERGE;
        if (sts_i.done) begin
          state_d = S_MEND;
        end
      end
      S_MEND: begin
        cmd.mend  = 1'b1;
        cmd.start = 1'b1;
        state_d   = (sts_i.op == OP_ALLOC) ? S_FIT : S_FRAG;
      end
      S_FIND: begin
        cmd.run  = 1'b1;
        cmd.mode = MD_FIND;
        if (sts_i.hit) begin
          if (sts_i.op == OP_CHECK) begin
            cmd.set_valid = sts_i.hit_use;
            cmd.start     = 1'b1;
            state_d       = S_FRAG;
          end else if (!sts_i.hit_use) begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_DOUBLE;
            cmd.start      = 1'b1;
            state_d        = S_FRAG;
          end else begin
            state_d = S_FREE;
          end
        end else if (sts_i.done) begin
          cmd.set_status = (sts_i.op == OP_FREE);
          cmd.status     = ST_UNKNOWN;
          cmd.start      = 1'b1;
          state_d        = S_FRAG;
        end
      end
      S_FREE: begin
        cmd.free_wr = 1'b1;
        cmd.start   = 1'b1;
        state_d     = S_MERGE;
      end
      S_FRAG: begin
        cmd.run  = 1'b1;
        cmd.mode = MD_FRAG;
        if (sts_i.done) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd.load_out = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign cmd_o      = cmd;
  assign in_stall_o = (state_q != S_IDLE);

endmodule

/* verif/tb.sv */
// Self-checking testbench for the first-fit block allocator unit.
`timescale 1ns / 1ps

module tb;
  import ffba_pkg::*;

  localparam int HEAP = 16384;
  localparam int HDR = 32;
  localparam int NBLK = 64;
  localparam int HANG_LIMIT = 20000;
  localparam int N_RANDOM = 425;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  req_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_rsp_o;

  first_fit_block_allocator_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_req_i(in_req_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_rsp_o(out_rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the heap table and statistics.
  int unsigned blk_off[NBLK];
  int unsigned blk_pay[NBLK];
  bit blk_used[NBLK];
  int unsigned blk_cnt;
  int unsigned use_now, use_peak;
  int unsigned n_allocs, n_frees;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int hang_cycles = 0;
  int n_rsps = 0;
  int n_fail_alloc = 0;
  bit in_taken = 1'b0;

  function automatic void merge_free();
    int unsigned i;
    i = 0;
    while (i + 1 < blk_cnt) begin
      if (!blk_used[i] && !blk_used[i+1]) begin
        blk_pay[i] += HDR + blk_pay[i+1];
        for (int unsigned k = i + 1; k + 1 < blk_cnt; k++) begin
          blk_off[k] = blk_off[k+1];
          blk_pay[k] = blk_pay[k+1];
          blk_used[k] = blk_used[k+1];
        end
        blk_cnt--;
      end else begin
        i++;
      end
    end
  endfunction

  function automatic int first_fit(int unsigned need);
    for (int unsigned i = 0; i < blk_cnt; i++)
      if (!blk_used[i] && blk_pay[i] >= need) return i;
    return -1;
  endfunction

  function automatic int find_block(int unsigned addr);
    for (int unsigned i = 0; i < blk_cnt; i++)
      if (blk_off[i] + HDR == addr) return i;
    return -1;
  endfunction

  function automatic int unsigned frag_pct();
    int unsigned cnt, big, tot;
    cnt = 0; big = 0; tot = 0;
    for (int unsigned i = 0; i < blk_cnt; i++)
      if (!blk_used[i]) begin
        cnt++;
        if (blk_pay[i] > big) big = blk_pay[i];
        tot += blk_pay[i];
      end
    if (tot == 0 || cnt <= 1) return 0;
    return 100 - (big * 100) / tot;
  endfunction

  // Applies one request to the shadow heap and returns the expected result.
  function automatic rsp_t heap_apply(req_t rq);
    rsp_t r;
    int idx;
    int unsigned need;
    r = '0;
    r.status = ST_OK;
    case (rq.operation)
      OP_ALLOC: begin
        if (rq.request_size == 0) begin
          r.status = ST_ZERO;
        end else begin
          need = (int'(rq.request_size) + 3) & ~32'd3;
          idx = first_fit(need);
          if (idx < 0) begin
            merge_free();
            idx = first_fit(need);
          end
          if (idx < 0) begin
            r.status = ST_NOMEM;
          end else begin
            if (blk_pay[idx] > need + HDR && blk_cnt < NBLK) begin
              for (int unsigned k = blk_cnt; k > idx + 1; k--) begin
                blk_off[k] = blk_off[k-1];
                blk_pay[k] = blk_pay[k-1];
                blk_used[k] = blk_used[k-1];
              end
              blk_off[idx+1] = blk_off[idx] + HDR + need;
              blk_pay[idx+1] = blk_pay[idx] - need - HDR;
              blk_used[idx+1] = 1'b0;
              blk_pay[idx] = need;
              blk_cnt++;
            end
            blk_used[idx] = 1'b1;
            use_now += blk_pay[idx];
            n_allocs++;
            if (use_now > use_peak) use_peak = use_now;
            r.granted_address = ADDR_W'(blk_off[idx] + HDR);
          end
        end
      end
      OP_FREE: begin
        idx = find_block(rq.address);
        if (idx < 0) begin
          r.status = ST_UNKNOWN;
        end else if (!blk_used[idx]) begin
          r.status = ST_DOUBLE;
        end else begin
          blk_used[idx] = 1'b0;
          use_now -= blk_pay[idx];
          n_frees++;
          merge_free();
        end
      end
      OP_CHECK: begin
        idx = find_block(rq.address);
        r.address_valid = (idx >= 0) && blk_used[idx];
      end
      default: ;
    endcase
    r.used_bytes = USE_W'(use_now);
    r.used_bytes_max = USE_W'(use_peak);
    r.allocation_count = n_allocs;
    r.free_count = n_frees;
    r.fragmentation_percent = PCT_W'(frag_pct());
    return r;
  endfunction

  // Driver: presents the next queued request once the current one is taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_req_i <= pending_reqs[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      in_taken = 1'b0;
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: compares each result transfer with the oldest expectation and
  // predicts each accepted request transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        n_rsps++;
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_rsp_o);
        end else begin
          if (out_rsp_o !== expected_rsps[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %p, got %p", expected_rsps[0], out_rsp_o);
          end
          if (expected_rsps[0].status == ST_NOMEM) n_fail_alloc++;
          void'(expected_rsps.pop_front());
        end
      end
      if (in_valid_i && !in_stall_o) begin
        expected_rsps.push_back(heap_apply(in_req_i));
        void'(pending_reqs.pop_front());
        in_taken = 1'b1;
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) hang_cycles = 0;
      else hang_cycles++;
      if (hang_cycles >= HANG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Pushes one request onto the queue of pending requests.
  task automatic push_req(op_e op, int unsigned sz, int unsigned addr);
    req_t rq;
    rq.operation = op;
    rq.request_size = REQ_W'(sz);
    rq.address = ADDR_W'(addr);
    pending_reqs.push_back(rq);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid_i || expected_rsps.size() > 0)
      @(posedge clk_i);
  endtask

  function automatic int unsigned pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(64, 1);
    if (r < 90) return $urandom_range(1024, 1);
    if (r < 97) return $urandom_range(HEAP, 1);
    return $urandom_range(32767);
  endfunction

  // Picks mostly payload addresses of blocks in the predictor table, else random or word-aligned ones.
  function automatic int unsigned pick_addr();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 75 && blk_cnt > 0) return blk_off[$urandom_range(blk_cnt - 1)] + HDR;
    if (r < 85) return $urandom_range(16383);
    return ($urandom_range(511) * 4) & 14'h3fff;
  endfunction

  initial begin
    int unsigned r;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < NBLK; i++) begin
      blk_off[i] = 0; blk_pay[i] = 0; blk_used[i] = 1'b0;
    end
    blk_pay[0] = HEAP - HDR;
    blk_cnt = 1; use_now = 0; use_peak = 0; n_allocs = 0; n_frees = 0;

    // Directed: zero size, odd sizes, whole heap, too large, free cases, checks.
    push_req(OP_STATS, 0, 0);
    push_req(OP_ALLOC, 0, 16383);
    push_req(OP_ALLOC, 1, 0);
    push_req(OP_ALLOC, 5, 0);
    push_req(OP_CHECK, 0, 32);
    push_req(OP_CHECK, 0, 33);
    push_req(OP_FREE, 32767, 32);
    push_req(OP_FREE, 0, 32);
    push_req(OP_CHECK, 0, 32);
    push_req(OP_FREE, 0, 16383);
    push_req(OP_ALLOC, 32767, 0);
    push_req(OP_ALLOC, 16384, 0);
    push_req(OP_ALLOC, 16352, 0);
    push_req(OP_STATS, 32767, 16383);
    push_req(OP_FREE, 0, 32);
    push_req(OP_ALLOC, 16321, 0);
    push_req(OP_FREE, 0, 32);
    // Fill the table so the no-split path is taken when it is full.
    for (int i = 0; i < NBLK; i++) push_req(OP_ALLOC, 4, 0);
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        3: begin send_idle_pct = 31; recv_stall_pct = 31; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int i = 0; i < N_RANDOM / 5; i++) begin
        // Address picks read the predictor table, so keep it current.
        wait_drained();
        r = $urandom_range(99);
        if (ph == 4 && r < 50) push_req(OP_ALLOC, $urandom_range(8, 1), 0);
        else if (r < 45) push_req(OP_ALLOC, pick_size(), $urandom_range(16383));
        else if (r < 75) push_req(OP_FREE, $urandom_range(32767), pick_addr());
        else if (r < 90) push_req(OP_CHECK, $urandom_range(32767), pick_addr());
        else push_req(OP_STATS, $urandom_range(32767), $urandom_range(16383));
      end
    end
    wait_drained();
    repeat (300) @(posedge clk_i);
    $display("Checked %0d results over directed and random requests.", n_rsps);
    $display("Out-of-memory results seen: %0d; peak usage %0d bytes.", n_fail_alloc, use_peak);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
